// ===== hw/rtl/cbt_pkg.sv =====
package cbt_pkg;

  // Width of the internal changed-character tally
  localparam int COUNT_BITS = 16;

  // Codeset codes (code 3 behaves as ASCII)
  localparam logic [1:0] CS_ASCII  = 2'd0;
  localparam logic [1:0] CS_UTF8   = 2'd1;
  localparam logic [1:0] CS_LATIN1 = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SOURCE_CODESET = 2'd0;
  localparam logic [1:0] REG_DEST_CODESET   = 2'd1;
  localparam logic [1:0] REG_OUTPUT_SPACE   = 2'd2;

  localparam logic [15:0] OUTPUT_SPACE_RESET = 16'hffff;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ILLEGAL    = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_end;
    logic [1:0]  status;
    logic        stream_end;
    logic [15:0] changed_count;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  source_codeset;
    logic [1:0]  dest_codeset;
    logic [15:0] output_space;
  } cfg_t;

  // Results of one input byte: one or two output beats
  typedef struct packed {
    logic      two_beats;
    out_beat_t beat0;
    out_beat_t beat1;
  } step_t;

endpackage

// ===== hw/rtl/cbt_cfg_regs.sv =====
module cbt_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output cbt_pkg::cfg_t      cfg
);
  import cbt_pkg::*;

  cfg_t cfg_q;

  // Register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.source_codeset <= CS_ASCII;
      cfg_q.dest_codeset   <= CS_ASCII;
      cfg_q.output_space   <= OUTPUT_SPACE_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SOURCE_CODESET: cfg_q.source_codeset <= cfg_data[1:0];
        REG_DEST_CODESET:   cfg_q.dest_codeset   <= cfg_data[1:0];
        REG_OUTPUT_SPACE:   cfg_q.output_space   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

// ===== hw/rtl/cbt_core.sv =====
module cbt_core (
  input  logic              clk,
  input  logic              rst,
  input  cbt_pkg::cfg_t     cfg,
  input  cbt_pkg::in_beat_t in_data,
  input  logic              accept,
  output cbt_pkg::step_t    step
);
  import cbt_pkg::*;

  logic [7:0]            lead_byte, lead_byte_next;
  logic                  lead_pending, lead_pending_next;
  logic [15:0]           bytes_written, bytes_written_next;
  logic [COUNT_BITS-1:0] changed_tally, changed_tally_next;
  status_t               error_code, error_code_next;

  logic [15:0] pair;
  logic        have;
  logic [10:0] scalar;
  logic [7:0]  first;
  logic [1:0]  n_enc, n_out;
  logic [7:0]  ob0, ob1;
  logic [15:0] room;
  logic [15:0] count_shown;

  // Decode, re-encode and budget check for one byte
  always_comb begin
    lead_byte_next     = lead_byte;
    lead_pending_next  = lead_pending;
    bytes_written_next = bytes_written;
    changed_tally_next = changed_tally;
    error_code_next    = error_code;
    pair   = {lead_byte, in_data.in_byte};
    have   = 1'b0;
    scalar = {3'b000, in_data.in_byte};
    first  = in_data.in_byte;
    n_enc  = 2'd0;
    n_out  = 2'd0;
    ob0    = 8'h00;
    ob1    = 8'h00;
    room   = (cfg.output_space >= bytes_written) ? cfg.output_space - bytes_written : 16'd0;

    if (error_code == ST_OK) begin
      // Source decode
      if (cfg.source_codeset == CS_UTF8) begin
        if (lead_pending) begin
          lead_pending_next = 1'b0;
          if ((pair & 16'he0c0) != 16'hc080) begin
            error_code_next = ST_ILLEGAL;
          end else begin
            scalar = {pair[12:8], pair[5:0]};
            first  = lead_byte;
            have   = 1'b1;
          end
        end else if (!in_data.in_byte[7]) begin
          have = 1'b1;
        end else if (in_data.final_byte) begin
          error_code_next = ST_INCOMPLETE;
        end else begin
          lead_byte_next    = in_data.in_byte;
          lead_pending_next = 1'b1;
        end
      end else begin
        lead_pending_next = 1'b0;
        if (cfg.source_codeset == CS_LATIN1 || !in_data.in_byte[7]) begin
          have = 1'b1;
        end else begin
          error_code_next = ST_ILLEGAL;
        end
      end

      // Destination encode
      case (cfg.dest_codeset)
        CS_UTF8: begin
          if (scalar < 11'h080) begin
            n_enc = 2'd1;
            ob0   = scalar[7:0];
          end else begin
            n_enc = 2'd2;
            ob0   = {3'b110, scalar[10:6]};
            ob1   = {2'b10, scalar[5:0]};
          end
        end
        CS_LATIN1: begin
          n_enc = (scalar > 11'h0ff) ? 2'd0 : 2'd1;
          ob0   = scalar[7:0];
        end
        default: begin
          n_enc = (scalar >= 11'h080) ? 2'd0 : 2'd1;
          ob0   = scalar[7:0];
        end
      endcase

      // Output budget and changed-character tally
      if (have) begin
        if ({14'd0, n_enc} > room) begin
          error_code_next = ST_FULL;
        end else begin
          n_out              = n_enc;
          bytes_written_next = bytes_written + {14'd0, n_enc};
          if (({3'b000, first} != scalar || n_enc == 2'd0) && !(&changed_tally)) begin
            changed_tally_next = changed_tally + COUNT_BITS'(1);
          end
        end
      end
    end

    // Tally as shown on the port, saturated to 16 bits
    count_shown = (|(changed_tally_next >> 16)) ? 16'hffff : 16'(changed_tally_next);

    step.two_beats              = (n_out == 2'd2);
    step.beat0.out_byte         = (n_out != 2'd0) ? ob0 : 8'h00;
    step.beat0.byte_valid       = (n_out != 2'd0);
    step.beat0.run_end          = (n_out != 2'd2);
    step.beat0.status           = error_code_next;
    step.beat0.stream_end       = (n_out != 2'd2) && in_data.final_byte;
    step.beat0.changed_count    = count_shown;
    step.beat1.out_byte         = ob1;
    step.beat1.byte_valid       = 1'b1;
    step.beat1.run_end          = 1'b1;
    step.beat1.status           = error_code_next;
    step.beat1.stream_end       = in_data.final_byte;
    step.beat1.changed_count    = count_shown;
  end

  // Stream state; cleared at reset and after a final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte     <= 8'h00;
      lead_pending  <= 1'b0;
      bytes_written <= 16'd0;
      changed_tally <= '0;
      error_code    <= ST_OK;
    end else if (accept) begin
      if (in_data.final_byte) begin
        lead_byte     <= 8'h00;
        lead_pending  <= 1'b0;
        bytes_written <= 16'd0;
        changed_tally <= '0;
        error_code    <= ST_OK;
      end else begin
        lead_byte     <= lead_byte_next;
        lead_pending  <= lead_pending_next;
        bytes_written <= bytes_written_next;
        changed_tally <= changed_tally_next;
        error_code    <= error_code_next;
      end
    end
  end

endmodule

// ===== hw/rtl/cbt_out_stage.sv =====
module cbt_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  cbt_pkg::step_t      step,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output cbt_pkg::out_beat_t  out_data
);
  import cbt_pkg::*;

  out_beat_t  slot0, slot1;
  logic [1:0] fill;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (fill != 2'd0);
  assign out_data  = slot0;
  // Room for a new byte's results when empty, or once the held beat leaves this cycle
  assign can_load  = (fill == 2'd0) || (fill == 2'd1 && out_ready);

  // Beat occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (load) begin
      fill <= step.two_beats ? 2'd2 : 2'd1;
    end else if (pop) begin
      fill <= fill - 2'd1;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= step.beat0;
      slot1 <= step.beat1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

// ===== hw/rtl/charset_byte_transcoder.sv =====
// Latency: results of a byte appear on out_data the cycle after it is accepted.
// Throughput: one input byte per cycle while out_ready is high; a byte that
// encodes to two output bytes occupies the output port for two beats, and the
// input waits for the second. The two-entry output stage sets this: a new byte
// loads when it is empty or its last beat leaves in the same cycle.
// Reset (rst, synchronous): registers to defaults, stream state and output stage cleared.
module charset_byte_transcoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  cbt_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cbt_pkg::out_beat_t  out_data
);
  import cbt_pkg::*;

  cfg_t  cfg;
  step_t step;
  logic  accept;

  assign accept = in_valid && in_ready;

  cbt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cbt_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_data (in_data),
    .accept  (accept),
    .step    (step)
  );

  cbt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .step      (step),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import cbt_pkg::*;

  // Index 3 of the register port decodes to nothing
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Spare codeset code, treated as ASCII on both sides
  localparam logic [1:0] CS_SPARE = 2'd3;
  localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam int PHASE_BYTES = 383;
  localparam int MAX_PRINTED = 40;

  logic       clk;
  logic       rst;
  logic       cfg_wen;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  in_beat_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_beat_t  out_data;

  charset_byte_transcoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One row of the directed plan: a register write or a source byte,
  // optionally with its single result beat written out by hand
  typedef struct packed {
    logic       is_reg;
    logic [1:0] idx;
    logic [15:0] val;
    logic       fin;
    logic       known;
    out_beat_t  beat;
  } plan_row_t;

  plan_row_t plan[$];
  out_beat_t out_due[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int mismatches;
  int bytes_sent;
  int beats_checked;
  int streams_done;
  int ends_by_status[4];

  // Shadow of the block: registers and stream state
  logic [1:0]        src_cs;
  logic [1:0]        dst_cs;
  logic [15:0]       space;
  logic [7:0]        lead;
  logic              lead_held;
  logic [15:0]       written;
  longint unsigned   tally;
  status_t           stream_err;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  task automatic clear_stream();
    lead = '0;
    lead_held = 1'b0;
    written = '0;
    tally = 0;
    stream_err = ST_OK;
  endtask

  // Decode one source byte, re-encode the character and give the beats it causes
  task automatic transcode_byte(input logic [7:0] b, input logic fin,
                                output out_beat_t r0, output out_beat_t r1,
                                output int n);
    logic        have;
    logic [10:0] sc;
    logic [7:0]  first;
    logic [15:0] pair;
    logic [7:0]  emit0;
    logic [7:0]  emit1;
    logic [15:0] shown;
    int          room;
    n = 0;
    have = 1'b0;
    sc = '0;
    first = b;
    emit0 = '0;
    emit1 = '0;
    if (stream_err == ST_OK) begin
      if (src_cs == CS_UTF8) begin
        if (lead_held) begin
          pair = {lead, b};
          lead_held = 1'b0;
          if ((pair & 16'he0c0) != 16'hc080) begin
            stream_err = ST_ILLEGAL;
          end else begin
            sc = {pair[12:8], pair[5:0]};
            first = lead;
            have = 1'b1;
          end
        end else if (b < 8'h80) begin
          sc = {3'b000, b};
          have = 1'b1;
        end else if (fin) begin
          stream_err = ST_INCOMPLETE;
        end else begin
          lead = b;
          lead_held = 1'b1;
        end
      end else begin
        // any held lead is dropped once the source is no longer UTF-8
        lead_held = 1'b0;
        if (src_cs == CS_LATIN1 || b < 8'h80) begin
          sc = {3'b000, b};
          have = 1'b1;
        end else begin
          stream_err = ST_ILLEGAL;
        end
      end

      if (have) begin
        if (dst_cs == CS_UTF8) begin
          if (sc < 11'h080) begin
            n = 1;
            emit0 = sc[7:0];
          end else begin
            n = 2;
            emit0 = {3'b110, sc[10:6]};
            emit1 = {2'b10, sc[5:0]};
          end
        end else if (dst_cs == CS_LATIN1) begin
          if (sc <= 11'h0ff) begin
            n = 1;
            emit0 = sc[7:0];
          end
        end else if (sc < 11'h080) begin
          n = 1;
          emit0 = sc[7:0];
        end
        room = (space >= written) ? int'(space) - int'(written) : 0;
        if (n > room) begin
          stream_err = ST_FULL;
          n = 0;
        end else begin
          written = written + 16'(n);
          if (({3'b000, first} != sc || n == 0) && tally < TALLY_MAX)
            tally++;
        end
      end
    end

    shown = (tally > 64'hffff) ? 16'hffff : tally[15:0];
    r0 = '0;
    r1 = '0;
    r0.status = stream_err;
    r1.status = stream_err;
    r0.changed_count = shown;
    r1.changed_count = shown;
    if (n > 0) begin
      r0.out_byte = emit0;
      r0.byte_valid = 1'b1;
      r1.out_byte = emit1;
      r1.byte_valid = 1'b1;
    end
    if (n == 2) begin
      r1.run_end = 1'b1;
      r1.stream_end = fin;
    end else begin
      r0.run_end = 1'b1;
      r0.stream_end = fin;
    end

    if (fin) begin
      ends_by_status[stream_err]++;
      streams_done++;
      clear_stream();
    end
  endtask

  // Offer one byte, hold it until taken, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic fin,
                           input logic known, input out_beat_t beat);
    out_beat_t r0;
    out_beat_t r1;
    int        n;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.in_byte <= b;
    in_data.final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    transcode_byte(b, fin, r0, r1, n);
    if (known) begin
      out_due.push_back(beat);
    end else begin
      out_due.push_back(r0);
      if (n == 2)
        out_due.push_back(r1);
    end
  endtask

  // Drop valid and let every outstanding beat drain, bounded
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (out_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_SOURCE_CODESET: src_cs = val[1:0];
      REG_DEST_CODESET: dst_cs = val[1:0];
      REG_OUTPUT_SPACE: space = val;
      default: ;
    endcase
  endtask

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic plan_row_t byte_row(input logic [7:0] b, input logic fin);
    plan_row_t r;
    r = '0;
    r.val = {8'h00, b};
    r.fin = fin;
    return r;
  endfunction

  // Byte whose single beat is obvious: no output or one plain byte
  function automatic plan_row_t known_row(input logic [7:0] b, input logic fin,
                                          input logic [7:0] ob, input logic ok,
                                          input status_t st, input logic [15:0] cnt);
    plan_row_t r;
    r = byte_row(b, fin);
    r.known = 1'b1;
    r.beat.out_byte = ob;
    r.beat.byte_valid = ok;
    r.beat.run_end = 1'b1;
    r.beat.status = st;
    r.beat.stream_end = fin;
    r.beat.changed_count = cnt;
    return r;
  endfunction

  // Occasionally move to a new register setting before a stream
  task automatic random_setup();
    logic [15:0] v;
    int          pick;
    if ($urandom_range(99) < 35) begin
      v = 16'($urandom);
      v[1:0] = 2'($urandom_range(3));
      if (v[1:0] != src_cs)
        write_reg(REG_SOURCE_CODESET, v);
      v = 16'($urandom);
      v[1:0] = 2'($urandom_range(3));
      if (v[1:0] != dst_cs)
        write_reg(REG_DEST_CODESET, v);
      pick = $urandom_range(9);
      if (pick < 6)
        v = 16'hffff;
      else if (pick < 9)
        v = 16'($urandom_range(40));
      else
        v = 16'($urandom);
      if (v != space)
        write_reg(REG_OUTPUT_SPACE, v);
    end
  endtask

  // Mostly well-formed text for the current source, now and then pure noise
  task automatic random_stream(input int len);
    logic [7:0] b;
    logic       cont_next;
    logic       noisy;
    int         i;
    cont_next = 1'b0;
    noisy = ($urandom_range(9) == 0);
    for (i = 0; i < len; i++) begin
      if (noisy) begin
        b = 8'($urandom_range(255));
      end else if (src_cs == CS_UTF8) begin
        if (cont_next) begin
          b = 8'($urandom_range(8'hbf, 8'h80));
          cont_next = 1'b0;
        end else if ($urandom_range(99) < 10) begin
          b = 8'($urandom_range(255));
        end else if ($urandom_range(1) == 1) begin
          b = 8'($urandom_range(127));
        end else begin
          b = 8'($urandom_range(8'hdf, 8'hc0));
          cont_next = 1'b1;
        end
      end else if (src_cs == CS_LATIN1) begin
        b = 8'($urandom_range(255));
      end else begin
        b = 8'(($urandom_range(99) < 8) ? $urandom_range(255) : $urandom_range(127));
      end
      send_byte(b, i == len - 1, 1'b0, '0);
    end
  endtask

  // Output side: random stalls, and every taken beat checked in order
  always @(posedge clk) begin : out_side
    out_beat_t want;
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
    if (!rst && out_valid && out_ready) begin
      if (out_due.size() == 0) begin
        report_mismatch($sformatf("beat %h with nothing outstanding", out_data));
      end else begin
        want = out_due.pop_front();
        beats_checked++;
        check_field("out_byte", 16'(out_data.out_byte), 16'(want.out_byte));
        check_field("byte_valid", 16'(out_data.byte_valid), 16'(want.byte_valid));
        check_field("run_end", 16'(out_data.run_end), 16'(want.run_end));
        check_field("status", 16'(out_data.status), 16'(want.status));
        check_field("stream_end", 16'(out_data.stream_end), 16'(want.stream_end));
        check_field("changed_count", out_data.changed_count, want.changed_count);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int start;
    int i;
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_index <= REG_SOURCE_CODESET;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    tx_idle_pct = 16;
    rx_idle_pct = 47;
    mismatches = 0;
    bytes_sent = 0;
    beats_checked = 0;
    streams_done = 0;
    for (i = 0; i < 4; i++)
      ends_by_status[i] = 0;
    src_cs = CS_ASCII;
    dst_cs = CS_ASCII;
    space = OUTPUT_SPACE_RESET;
    clear_stream();

    // ASCII limits, bad high bytes and a sticky error
    plan.push_back(known_row(8'h00, 1'b0, 8'h00, 1'b1, ST_OK, 16'd0));
    plan.push_back(known_row(8'h7f, 1'b0, 8'h7f, 1'b1, ST_OK, 16'd0));
    plan.push_back(known_row(8'h80, 1'b1, 8'h00, 1'b0, ST_ILLEGAL, 16'd0));
    plan.push_back(known_row(8'hff, 1'b0, 8'h00, 1'b0, ST_ILLEGAL, 16'd0));
    plan.push_back(known_row(8'h41, 1'b1, 8'h00, 1'b0, ST_ILLEGAL, 16'd0));
    // Latin-1 into UTF-8: two-byte forms
    plan.push_back(reg_row(REG_SOURCE_CODESET, {14'd0, CS_LATIN1}));
    plan.push_back(reg_row(REG_DEST_CODESET, {14'd0, CS_UTF8}));
    plan.push_back(byte_row(8'he9, 1'b0));
    plan.push_back(byte_row(8'hff, 1'b1));
    // UTF-8 into Latin-1: held lead, unchanged pair, drop, overlong, bad pair
    plan.push_back(reg_row(REG_SOURCE_CODESET, {14'd0, CS_UTF8}));
    plan.push_back(reg_row(REG_DEST_CODESET, {14'd0, CS_LATIN1}));
    plan.push_back(known_row(8'hc3, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0));
    plan.push_back(byte_row(8'ha9, 1'b0));
    plan.push_back(byte_row(8'hc3, 1'b0));
    plan.push_back(byte_row(8'h83, 1'b0));
    plan.push_back(byte_row(8'hc4, 1'b0));
    plan.push_back(byte_row(8'h80, 1'b0));
    plan.push_back(byte_row(8'hc0, 1'b0));
    plan.push_back(byte_row(8'h80, 1'b0));
    plan.push_back(byte_row(8'hc3, 1'b0));
    plan.push_back(byte_row(8'h41, 1'b0));
    plan.push_back(byte_row(8'h00, 1'b1));
    // lead byte as the last of a stream
    plan.push_back(known_row(8'hc2, 1'b1, 8'h00, 1'b0, ST_INCOMPLETE, 16'd0));
    // lead left pending while the source changes away from UTF-8
    plan.push_back(byte_row(8'hdf, 1'b0));
    plan.push_back(reg_row(REG_SOURCE_CODESET, {14'd0, CS_ASCII}));
    plan.push_back(reg_row(REG_SOURCE_CODESET, {14'd0, CS_SPARE}));
    plan.push_back(byte_row(8'h41, 1'b1));
    // budget of one byte, then none
    plan.push_back(reg_row(REG_DEST_CODESET, {14'd0, CS_SPARE}));
    plan.push_back(reg_row(REG_OUTPUT_SPACE, 16'd1));
    plan.push_back(byte_row(8'h42, 1'b0));
    plan.push_back(known_row(8'h43, 1'b0, 8'h00, 1'b0, ST_FULL, 16'd0));
    plan.push_back(known_row(8'h44, 1'b1, 8'h00, 1'b0, ST_FULL, 16'd0));
    plan.push_back(reg_row(REG_SOURCE_CODESET, {14'd0, CS_LATIN1}));
    plan.push_back(reg_row(REG_DEST_CODESET, {14'd0, CS_UTF8}));
    plan.push_back(known_row(8'he9, 1'b1, 8'h00, 1'b0, ST_FULL, 16'd0));
    plan.push_back(reg_row(REG_OUTPUT_SPACE, 16'd0));
    plan.push_back(known_row(8'h20, 1'b1, 8'h00, 1'b0, ST_FULL, 16'd0));
    // unused index must leave everything alone
    plan.push_back(reg_row(REG_UNUSED, 16'h0001));
    plan.push_back(reg_row(REG_OUTPUT_SPACE, 16'hffff));
    plan.push_back(byte_row(8'h80, 1'b1));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].is_reg)
        write_reg(plan[k].idx, plan[k].val);
      else
        send_byte(plan[k].val[7:0], plan[k].fin, plan[k].known, plan[k].beat);
    end

    // Random streams under three idling profiles
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 47;
        end
        1: begin
          tx_idle_pct = 47;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        random_setup();
        random_stream($urandom_range(24, 1));
      end
    end

    wait_idle();
    if (out_due.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", out_due.size()));

    $display("Sent %0d source bytes in %0d streams; %0d output beats checked",
             bytes_sent, streams_done, beats_checked);
    $display("Stream endings ok/illegal/incomplete/full: %0d/%0d/%0d/%0d",
             ends_by_status[ST_OK], ends_by_status[ST_ILLEGAL],
             ends_by_status[ST_INCOMPLETE], ends_by_status[ST_FULL]);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
